>>> design/kwl_pkg.sv
// Package for the keyword lexer: widths, codes, character constants and shared helpers.
package kwl_pkg;

	localparam int POSITION_BITS = 16;
	localparam int KEYWORD_CHARS = 6;
	localparam int PREFIX_W      = 8 * KEYWORD_CHARS;
	localparam int TOK_W         = 16;
	localparam int FIFO_DEPTH    = 4;
	localparam int PTR_W         = $clog2(FIFO_DEPTH);
	localparam int CNT_W         = $clog2(FIFO_DEPTH + 1);

	localparam logic [TOK_W-1:0] LEN_MAX = '1;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_STRING = 2'd1,
		MODE_NUMBER = 2'd2,
		MODE_WORD   = 2'd3
	} mode_t;

	typedef enum logic [3:0] {
		KIND_CONST  = 4'd0,
		KIND_LPAREN = 4'd1,
		KIND_RPAREN = 4'd2,
		KIND_COMMA  = 4'd3,
		KIND_COLON  = 4'd4,
		KIND_DEFN   = 4'd5,
		KIND_RETURN = 4'd6,
		KIND_INT    = 4'd7,
		KIND_FLOAT  = 4'd8,
		KIND_STR    = 4'd9,
		KIND_BOOL   = 4'd10,
		KIND_VOID   = 4'd11,
		KIND_IDENT  = 4'd12,
		KIND_ERROR  = 4'd13
	} kind_t;

	// Character codes
	localparam logic [7:0] CH_TAB        = 8'h09;
	localparam logic [7:0] CH_NEWLINE    = 8'h0a;
	localparam logic [7:0] CH_SPACE      = 8'h20;
	localparam logic [7:0] CH_QUOTE      = 8'h22;
	localparam logic [7:0] CH_LPAREN     = 8'h28;
	localparam logic [7:0] CH_RPAREN     = 8'h29;
	localparam logic [7:0] CH_COMMA      = 8'h2c;
	localparam logic [7:0] CH_DOT        = 8'h2e;
	localparam logic [7:0] CH_COLON      = 8'h3a;
	localparam logic [7:0] CH_UNDERSCORE = 8'h5f;

	// Keywords packed with the first character in the low byte
	localparam logic [PREFIX_W-1:0] KW_DEFN   = PREFIX_W'(48'h0000_6e66_6564);
	localparam logic [PREFIX_W-1:0] KW_RETURN = PREFIX_W'(48'h6e72_7574_6572);
	localparam logic [PREFIX_W-1:0] KW_INT    = PREFIX_W'(48'h0000_0074_6e69);
	localparam logic [PREFIX_W-1:0] KW_FLOAT  = PREFIX_W'(48'h0074_616f_6c66);
	localparam logic [PREFIX_W-1:0] KW_STR    = PREFIX_W'(48'h0000_0072_7473);
	localparam logic [PREFIX_W-1:0] KW_BOOL   = PREFIX_W'(48'h0000_6c6f_6f62);
	localparam logic [PREFIX_W-1:0] KW_VOID   = PREFIX_W'(48'h0000_6469_6f76);

	typedef struct packed {
		kind_t            kind;
		logic [TOK_W-1:0] start;
		logic [TOK_W-1:0] length;
		logic             last;
	} token_t;

	typedef struct packed {
		logic [1:0] count;
		token_t     first;
		token_t     second;
	} step_out_t;

	function automatic logic is_digit(input logic [7:0] c);
		return (c >= 8'h30) && (c <= 8'h39);
	endfunction

	function automatic logic is_word_char(input logic [7:0] c);
		return ((c >= 8'h61) && (c <= 8'h7a)) || ((c >= 8'h41) && (c <= 8'h5a))
			|| (c == CH_UNDERSCORE);
	endfunction

	function automatic kind_t classify_word(input logic [PREFIX_W-1:0] prefix,
		input logic [TOK_W-1:0] len);
		kind_t k;
		k = KIND_IDENT;
		priority if (len == TOK_W'(4) && prefix == KW_DEFN)   k = KIND_DEFN;
		else if (len == TOK_W'(6) && prefix == KW_RETURN)     k = KIND_RETURN;
		else if (len == TOK_W'(3) && prefix == KW_INT)        k = KIND_INT;
		else if (len == TOK_W'(5) && prefix == KW_FLOAT)      k = KIND_FLOAT;
		else if (len == TOK_W'(3) && prefix == KW_STR)        k = KIND_STR;
		else if (len == TOK_W'(4) && prefix == KW_BOOL)       k = KIND_BOOL;
		else if (len == TOK_W'(4) && prefix == KW_VOID)       k = KIND_VOID;
		else                                                  k = KIND_IDENT;
		return k;
	endfunction

	function automatic token_t make_token(input kind_t kind, input logic [TOK_W-1:0] start,
		input logic [TOK_W-1:0] length);
		token_t t;
		t.kind   = kind;
		t.start  = start;
		t.length = length;
		t.last   = 1'b0;
		return t;
	endfunction

endpackage

>>> design/kwl_if.sv
// Channel interfaces of the keyword lexer: character input and token output.
interface kwl_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] ch;
	logic       end_of_input;

	modport source (output valid, output ch, output end_of_input, input ready);
	modport sink   (input valid, input ch, input end_of_input, output ready);
endinterface

interface kwl_token_if;
	logic        valid;
	logic        ready;
	logic [3:0]  token_kind;
	logic [15:0] token_start;
	logic [15:0] token_length;
	logic        last_of_run;

	modport source (output valid, output token_kind, output token_start,
		output token_length, output last_of_run, input ready);
	modport sink   (input valid, input token_kind, input token_start,
		input token_length, input last_of_run, output ready);
endinterface

>>> design/keyword_lexer.sv
// Keyword lexer top level: input register, step logic and result queue.
// Path: a character taken goes into the input register; the step logic lexes it from there once the
//   queue has room, and its tokens are written into the result queue, which feeds the token channel.
// Throughput: one character per cycle while the four-entry queue has room for two tokens;
//   the token channel gives one token per cycle while ready is high, a character's two in turn.
// Reset: arst_n clears lexer state, position counter, input register and queue at once.
module keyword_lexer (
	input  logic        clk,
	input  logic        arst_n,
	kwl_char_if.sink    chars,
	kwl_token_if.source tokens
);
	import kwl_pkg::*;

	// Input register: hold one character until the step logic takes it
	logic       valid_s1;
	logic [7:0] ch_s1;
	logic       eoi_s1;

	logic       space_ok;
	logic       fire;
	step_out_t  result;
	step_out_t  push;

	// Advance the character only when the queue can take every token it may cause
	assign fire        = valid_s1 && space_ok;
	assign chars.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (chars.ready) begin
			valid_s1 <= chars.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (chars.valid && chars.ready) begin
			ch_s1  <= chars.ch;
			eoi_s1 <= chars.end_of_input;
		end
	end

	kwl_step u_step (
		.clk          (clk),
		.arst_n       (arst_n),
		.fire         (fire),
		.ch           (ch_s1),
		.end_of_input (eoi_s1),
		.result       (result)
	);

	// Drop the tokens of a step that does not fire
	always_comb begin
		push = result;
		if (!fire)
			push.count = 2'd0;
	end

	kwl_token_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.space_ok (space_ok),
		.tokens   (tokens)
	);

endmodule

>>> design/kwl_step.sv
// Lexer state registers and the single-pass step logic for one character.
module kwl_step (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 fire,
	input  logic [7:0]           ch,
	input  logic                 end_of_input,
	output kwl_pkg::step_out_t   result
);
	import kwl_pkg::*;

	mode_t                    mode_q;
	logic [POSITION_BITS-1:0] pos_q;
	logic [POSITION_BITS-1:0] start_q;
	logic [PREFIX_W-1:0]      prefix_q;
	logic [TOK_W-1:0]         len_q;

	mode_t                    mode_mid, mode_d;
	logic [POSITION_BITS-1:0] start_mid, start_d, pos_d, pos_inc;
	logic [PREFIX_W-1:0]      prefix_mid, prefix_d;
	logic [TOK_W-1:0]         len_mid, len_d, len_inc;
	logic                     taken;
	logic                     r1_v, r2_v, r3_v;
	token_t                   r1, r2, r3;

	function automatic logic [PREFIX_W-1:0] add_char(input logic [PREFIX_W-1:0] p,
		input logic [TOK_W-1:0] len, input logic [7:0] c);
		logic [PREFIX_W-1:0] r;
		r = p;
		for (int i = 0; i < KEYWORD_CHARS; i++) begin
			if (len == TOK_W'(i))
				r[8*i +: 8] = c;
		end
		return r;
	endfunction

	assign pos_inc = (pos_q == '1) ? pos_q : pos_q + 1'b1;
	assign len_inc = (len_q == LEN_MAX) ? len_q : len_q + 1'b1;

	always_comb begin
		mode_mid   = mode_q;
		start_mid  = start_q;
		prefix_mid = prefix_q;
		len_mid    = len_q;
		taken      = 1'b0;
		r1_v       = 1'b0;
		r2_v       = 1'b0;
		r3_v       = 1'b0;
		r1         = make_token(KIND_CONST, TOK_W'(start_q), len_q);
		r2         = make_token(KIND_ERROR, TOK_W'(pos_q), TOK_W'(1));
		r3         = make_token(KIND_CONST, TOK_W'(start_mid), len_mid);

		// Continue or close the pending token
		unique case (mode_q)
			MODE_STRING: begin
				taken = 1'b1;
				if (ch == CH_QUOTE) begin
					r1_v       = 1'b1;
					mode_mid   = MODE_IDLE;
					prefix_mid = '0;
					len_mid    = '0;
				end else begin
					len_mid = len_inc;
				end
			end
			MODE_NUMBER: begin
				if (is_digit(ch) || ch == CH_DOT) begin
					len_mid = len_inc;
					taken   = 1'b1;
				end else begin
					r1_v       = 1'b1;
					mode_mid   = MODE_IDLE;
					prefix_mid = '0;
					len_mid    = '0;
				end
			end
			MODE_WORD: begin
				if (is_word_char(ch)) begin
					prefix_mid = add_char(prefix_q, len_q, ch);
					len_mid    = len_inc;
					taken      = 1'b1;
				end else begin
					r1_v       = 1'b1;
					r1.kind    = classify_word(prefix_q, len_q);
					mode_mid   = MODE_IDLE;
					prefix_mid = '0;
					len_mid    = '0;
				end
			end
			MODE_IDLE: begin
			end
		endcase

		// Start a new token from this character
		if (!taken) begin
			priority if (ch == CH_SPACE || ch == CH_TAB || ch == CH_NEWLINE) begin
			end else if (ch == CH_QUOTE) begin
				if (!end_of_input) begin
					mode_mid   = MODE_STRING;
					start_mid  = pos_inc;
					prefix_mid = '0;
					len_mid    = '0;
				end
			end else if (ch == CH_LPAREN) begin
				r2_v    = 1'b1;
				r2.kind = KIND_LPAREN;
			end else if (ch == CH_RPAREN) begin
				r2_v    = 1'b1;
				r2.kind = KIND_RPAREN;
			end else if (ch == CH_COMMA) begin
				r2_v    = 1'b1;
				r2.kind = KIND_COMMA;
			end else if (ch == CH_COLON) begin
				r2_v    = 1'b1;
				r2.kind = KIND_COLON;
			end else if (is_digit(ch)) begin
				mode_mid   = MODE_NUMBER;
				start_mid  = pos_q;
				prefix_mid = '0;
				len_mid    = TOK_W'(1);
			end else if (is_word_char(ch)) begin
				mode_mid   = MODE_WORD;
				start_mid  = pos_q;
				prefix_mid = PREFIX_W'(ch);
				len_mid    = TOK_W'(1);
			end else begin
				r2_v = 1'b1;
			end
		end

		// End of text closes whatever is still pending
		r3 = make_token(KIND_CONST, TOK_W'(start_mid), len_mid);
		if (end_of_input) begin
			unique case (mode_mid)
				MODE_STRING, MODE_NUMBER: r3_v = 1'b1;
				MODE_WORD: begin
					r3_v    = 1'b1;
					r3.kind = classify_word(prefix_mid, len_mid);
				end
				MODE_IDLE: r3_v = 1'b0;
			endcase
		end

		result.count  = 2'(r1_v) + 2'(r2_v) + 2'(r3_v);
		result.first  = r1_v ? r1 : (r2_v ? r2 : r3);
		result.second = (r1_v && r2_v) ? r2 : r3;
		result.first.last  = (result.count == 2'd1);
		result.second.last = 1'b1;

		if (end_of_input) begin
			mode_d   = MODE_IDLE;
			pos_d    = '0;
			start_d  = '0;
			prefix_d = '0;
			len_d    = '0;
		end else begin
			mode_d   = mode_mid;
			pos_d    = pos_inc;
			start_d  = start_mid;
			prefix_d = prefix_mid;
			len_d    = len_mid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			start_q  <= '0;
			prefix_q <= '0;
			len_q    <= '0;
		end else if (fire) begin
			mode_q   <= mode_d;
			pos_q    <= pos_d;
			start_q  <= start_d;
			prefix_q <= prefix_d;
			len_q    <= len_d;
		end
	end

endmodule

>>> design/kwl_token_fifo.sv
// Result queue: takes up to two tokens a cycle and hands out one per transaction.
module kwl_token_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  kwl_pkg::step_out_t push,
	output logic               space_ok,
	kwl_token_if.source        tokens
);
	import kwl_pkg::*;

	token_t           mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;
	token_t           head;

	assign space_ok = count_q <= CNT_W'(FIFO_DEPTH - 2);
	assign pop      = (count_q != '0) && tokens.ready;
	assign head     = mem[rd_q];

	assign tokens.valid        = (count_q != '0);
	assign tokens.token_kind   = head.kind;
	assign tokens.token_start  = head.start;
	assign tokens.token_length = head.length;
	assign tokens.last_of_run  = head.last;

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wr_q] <= push.first;
		if (push.count == 2'd2)
			mem[PTR_W'(wr_q + 1'b1)] <= push.second;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= PTR_W'(wr_q + PTR_W'(push.count));
			rd_q    <= PTR_W'(rd_q + PTR_W'(pop));
			count_q <= CNT_W'(count_q + CNT_W'(push.count) - CNT_W'(pop));
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(FIFO_DEPTH))
		else $error("token queue overfilled");

	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		(push.count != 2'd0) |-> (count_q <= CNT_W'(FIFO_DEPTH - 2)))
		else $error("tokens pushed without room for two");

	a_count_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (count_q == CNT_W'($past(count_q) + CNT_W'($past(push.count))
			- CNT_W'($past(pop)))))
		else $error("token queue fill level lost track");

endmodule
